### hdl/iptcp_pkg.sv
// Package for the IPv4/TCP header parser: beat and result types, verdict codes,
// header offsets and register map constants. Depends on nothing.
`timescale 1ns / 1ps

package iptcp_pkg;

   localparam int COUNTER_BITS_DEFAULT = 32;
   localparam int PADDR_BITS = 3;
   localparam int PDATA_BITS = 32;

   localparam logic [0:0] REG_LINK_FRAMING = 1'b0;

   localparam logic [8:0] HDR_ETHERNET = 9'd14;
   localparam logic [8:0] HDR_COOKED = 9'd16;
   localparam logic [8:0] MIN_HDR = 9'd20;
   localparam logic [15:0] TYPE_IPV4 = 16'h0800;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [3:0] MIN_WORDS = 4'd5;

   typedef enum logic [3:0] {
      VERDICT_TCP_OK = 4'd0,
      VERDICT_LINK_TRUNC = 4'd1,
      VERDICT_NON_IP = 4'd2,
      VERDICT_PRE_IP_TRUNC = 4'd3,
      VERDICT_BAD_IHL = 4'd4,
      VERDICT_IP_TRUNC = 4'd5,
      VERDICT_NON_TCP = 4'd6,
      VERDICT_PRE_TCP_TRUNC = 4'd7,
      VERDICT_BAD_OFFSET = 4'd8,
      VERDICT_TCP_TRUNC = 4'd9
   } verdict_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic end_of_packet;
      logic link_framing;
   } beat_type;

   typedef struct packed {
      verdict_type verdict;
      logic [15:0] frame_type;
      logic [7:0] transport_protocol;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] src_port;
      logic [15:0] destination_port;
      logic [31:0] sequence_number;
      logic [31:0] acknowledgment_number;
      logic [15:0] payload_bytes;
      logic [31:0] packets_seen;
      logic [31:0] tcp_packets_seen;
   } result_type;

endpackage

### hdl/iptcp_field_capture.sv
// Header field capture and classification for the IPv4/TCP header parser.
// Holds the per-packet header registers and the packet counters; uses iptcp_pkg.
`timescale 1ns / 1ps

module iptcp_field_capture
   import iptcp_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic beat_advance,
   input  beat_type beat,
   output result_type result
);

   logic [7:0] pos_ff, pos_in;
   logic [15:0] type_ff, type_in;
   logic [3:0] ihl_ff, ihl_in;
   logic [15:0] total_ff, total_in;
   logic [7:0] proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [31:0] ports_ff, ports_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] ack_ff, ack_in;
   logic [3:0] offset_ff, offset_in;
   logic [COUNTER_BITS-1:0] seen_ff, seen_in;
   logic [COUNTER_BITS-1:0] tcp_ff, tcp_in;

   logic [8:0] hdr_len;
   logic [8:0] pos9;
   logic [8:0] tcp_base;
   logic [8:0] len9;
   logic [8:0] ip_bytes;
   logic [8:0] tcp_bytes;
   logic [8:0] class_base;
   logic [15:0] hdrs;
   verdict_type verdict;

   assign hdr_len = beat.link_framing ? HDR_COOKED : HDR_ETHERNET;
   assign pos9 = {1'b0, pos_ff};
   assign tcp_base = hdr_len + {3'b000, ihl_ff, 2'b00};

   always_comb begin
      type_in = type_ff;
      ihl_in = ihl_ff;
      total_in = total_ff;
      proto_in = proto_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      ports_in = ports_ff;
      seq_in = seq_ff;
      ack_in = ack_ff;
      offset_in = offset_ff;
      if (pos9 == hdr_len - 9'd2) begin
         type_in[15:8] = beat.data_byte;
      end
      if (pos9 == hdr_len - 9'd1) begin
         type_in[7:0] = beat.data_byte;
      end
      if (pos9 == hdr_len) begin
         ihl_in = beat.data_byte[3:0];
      end
      if (pos9 == hdr_len + 9'd2) begin
         total_in[15:8] = beat.data_byte;
      end
      if (pos9 == hdr_len + 9'd3) begin
         total_in[7:0] = beat.data_byte;
      end
      if (pos9 == hdr_len + 9'd9) begin
         proto_in = beat.data_byte;
      end
      if (pos9 >= hdr_len + 9'd12 && pos9 <= hdr_len + 9'd15) begin
         src_in[(2'(hdr_len + 9'd15 - pos9)) * 8 +: 8] = beat.data_byte;
      end
      if (pos9 >= hdr_len + 9'd16 && pos9 <= hdr_len + 9'd19) begin
         dst_in[(2'(hdr_len + 9'd19 - pos9)) * 8 +: 8] = beat.data_byte;
      end
      if (pos9 > hdr_len && ihl_ff >= MIN_WORDS) begin
         if (pos9 >= tcp_base && pos9 <= tcp_base + 9'd3) begin
            ports_in[(2'(tcp_base + 9'd3 - pos9)) * 8 +: 8] = beat.data_byte;
         end
         if (pos9 >= tcp_base + 9'd4 && pos9 <= tcp_base + 9'd7) begin
            seq_in[(2'(tcp_base + 9'd7 - pos9)) * 8 +: 8] = beat.data_byte;
         end
         if (pos9 >= tcp_base + 9'd8 && pos9 <= tcp_base + 9'd11) begin
            ack_in[(2'(tcp_base + 9'd11 - pos9)) * 8 +: 8] = beat.data_byte;
         end
         if (pos9 == tcp_base + 9'd12) begin
            offset_in = beat.data_byte[7:4];
         end
      end
   end

   assign len9 = pos9 + 9'd1;
   assign ip_bytes = {3'b000, ihl_in, 2'b00};
   assign tcp_bytes = {3'b000, offset_in, 2'b00};
   assign class_base = hdr_len + ip_bytes;

   always_comb begin
      if (len9 < hdr_len) begin
         verdict = VERDICT_LINK_TRUNC;
      end else if (type_in != TYPE_IPV4) begin
         verdict = VERDICT_NON_IP;
      end else if (len9 < hdr_len + MIN_HDR) begin
         verdict = VERDICT_PRE_IP_TRUNC;
      end else if (ip_bytes < MIN_HDR) begin
         verdict = VERDICT_BAD_IHL;
      end else if (len9 < class_base) begin
         verdict = VERDICT_IP_TRUNC;
      end else if (proto_in != PROTO_TCP) begin
         verdict = VERDICT_NON_TCP;
      end else if (len9 < class_base + MIN_HDR) begin
         verdict = VERDICT_PRE_TCP_TRUNC;
      end else if (tcp_bytes < MIN_HDR) begin
         verdict = VERDICT_BAD_OFFSET;
      end else if (len9 < class_base + tcp_bytes) begin
         verdict = VERDICT_TCP_TRUNC;
      end else begin
         verdict = VERDICT_TCP_OK;
      end
   end

   assign hdrs = {7'b0, ip_bytes + tcp_bytes};
   assign seen_in = seen_ff + COUNTER_BITS'(1);
   assign tcp_in = (verdict == VERDICT_TCP_OK) ? tcp_ff + COUNTER_BITS'(1) : tcp_ff;
   assign pos_in = (pos_ff == 8'hFF) ? pos_ff : pos_ff + 8'd1;

   always_comb begin
      result = '0;
      result.verdict = verdict;
      result.packets_seen = 32'(seen_in);
      result.tcp_packets_seen = 32'(tcp_in);
      if (verdict != VERDICT_LINK_TRUNC) begin
         result.frame_type = type_in;
      end
      if (verdict == VERDICT_TCP_OK || verdict >= VERDICT_NON_TCP) begin
         result.transport_protocol = proto_in;
         result.source_address = src_in;
         result.destination_address = dst_in;
      end
      if (verdict == VERDICT_TCP_OK) begin
         result.src_port = ports_in[31:16];
         result.destination_port = ports_in[15:0];
         result.sequence_number = seq_in;
         result.acknowledgment_number = ack_in;
         result.payload_bytes = (total_in >= hdrs) ? total_in - hdrs : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (beat_advance && beat.end_of_packet)) begin
         pos_ff <= '0;
         type_ff <= '0;
         ihl_ff <= '0;
         total_ff <= '0;
         proto_ff <= '0;
         src_ff <= '0;
         dst_ff <= '0;
         ports_ff <= '0;
         seq_ff <= '0;
         ack_ff <= '0;
         offset_ff <= '0;
      end else if (beat_advance) begin
         pos_ff <= pos_in;
         type_ff <= type_in;
         ihl_ff <= ihl_in;
         total_ff <= total_in;
         proto_ff <= proto_in;
         src_ff <= src_in;
         dst_ff <= dst_in;
         ports_ff <= ports_in;
         seq_ff <= seq_in;
         ack_ff <= ack_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         tcp_ff <= '0;
      end else if (beat_advance && beat.end_of_packet) begin
         seen_ff <= seen_in;
         tcp_ff <= tcp_in;
      end
   end

endmodule

### hdl/ipv4_tcp_header_parser.sv
// Streaming IPv4/TCP header parser: one packet byte per beat, one result per packet.
// A final byte's result is held in the input register, then the result register.
// Throughput: one byte per cycle; a final byte waits while the held response is stalled.
// Reset (synchronous, active high) clears counters, header state and framing to Ethernet.
// Uses iptcp_pkg and iptcp_field_capture.
`timescale 1ns / 1ps

module ipv4_tcp_header_parser
   import iptcp_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_data_byte,
   input  logic req_end_of_packet,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [3:0] rsp_verdict,
   output logic [15:0] rsp_frame_type,
   output logic [7:0] rsp_transport_protocol,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_destination_address,
   output logic [15:0] rsp_src_port,
   output logic [15:0] rsp_destination_port,
   output logic [31:0] rsp_sequence_number,
   output logic [31:0] rsp_acknowledgment_number,
   output logic [15:0] rsp_payload_bytes,
   output logic [31:0] rsp_packets_seen,
   output logic [31:0] rsp_tcp_packets_seen,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [PDATA_BITS-1:0] pwdata,
   output logic [PDATA_BITS-1:0] prdata,
   output logic pready
);

   logic framing_ff;
   logic full_ff;
   beat_type beat_ff;
   logic rsp_valid_ff;
   result_type rsp_ff;
   result_type result_in;
   logic out_free;
   logic beat_advance;
   logic req_accept;
   logic reg_hit;

   assign pready = 1'b1;
   assign reg_hit = (paddr[PADDR_BITS-1:2] == REG_LINK_FRAMING);
   assign prdata = reg_hit ? {{(PDATA_BITS-1){1'b0}}, framing_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         framing_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         framing_ff <= pwdata[0];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign beat_advance = full_ff && (!beat_ff.end_of_packet || out_free);
   assign req_stall = full_ff && !beat_advance;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (req_accept) begin
         full_ff <= 1'b1;
      end else if (beat_advance) begin
         full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         beat_ff.data_byte <= req_data_byte;
         beat_ff.end_of_packet <= req_end_of_packet;
         beat_ff.link_framing <= framing_ff;
      end
   end

   iptcp_field_capture #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_capture (
      .clock(clock),
      .reset(reset),
      .beat_advance(beat_advance),
      .beat(beat_ff),
      .result(result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (beat_advance && beat_ff.end_of_packet) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_advance && beat_ff.end_of_packet) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_verdict = rsp_ff.verdict;
   assign rsp_frame_type = rsp_ff.frame_type;
   assign rsp_transport_protocol = rsp_ff.transport_protocol;
   assign rsp_source_address = rsp_ff.source_address;
   assign rsp_destination_address = rsp_ff.destination_address;
   assign rsp_src_port = rsp_ff.src_port;
   assign rsp_destination_port = rsp_ff.destination_port;
   assign rsp_sequence_number = rsp_ff.sequence_number;
   assign rsp_acknowledgment_number = rsp_ff.acknowledgment_number;
   assign rsp_payload_bytes = rsp_ff.payload_bytes;
   assign rsp_packets_seen = rsp_ff.packets_seen;
   assign rsp_tcp_packets_seen = rsp_ff.tcp_packets_seen;

endmodule
